// File: rtl/crte_pkg.sv
package crte_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF     = 32;

    localparam int FUNC_W     = 2;
    localparam int NOW_W      = 32;
    localparam int THR_W      = 8;
    localparam int WIN_W      = 16;
    localparam int TIER_W     = 3;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIER = 2'd2;

    localparam logic [TIER_W-1:0] TIER_NORMAL = 3'd0;
    localparam logic [TIER_W-1:0] TIER_NO_EXT = 3'd1;
    localparam logic [TIER_W-1:0] TIER_FULL   = 3'd4;

    localparam logic [THR_W-1:0]  THRESHOLD_RST  = 8'd3;
    localparam logic [WIN_W-1:0]  WINDOW_RST     = 16'd60;
    localparam logic [TIER_W-1:0] START_TIER_RST = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic last_issue;
        logic out_free;
    } t_status;

endpackage

// File: rtl/crash_rate_tier_escalator_unit.sv
// fault-rate escalation monitor over a sliding window of event times
// input words: tuser carries the operation (record, query, clear), tdata the
// current time. record prunes stored times older than the window, stores the
// new time (overwriting the oldest when the history is full), counts the
// stored events and recommends a tier; the highest tier seen is held sticky.
// output words: current tier, recommended tier and in-window count.
// config: index/data write channel, always ready; write only while idle.
// record and query read the time history one entry per cycle through a
// single registered ram read port; after the scan, a last state evaluates
// the final entry, and the update state then writes the result into the
// output register. clear skips the scan and goes from acceptance straight
// to the update state.
// one item is in work at a time; a finished result waits in the output
// register, and the next item is accepted meanwhile but cannot complete
// until the receiver takes it. reset empties the history, clears the sticky
// tier and loads the register defaults (threshold 3, window 60, start 0).
module crash_rate_tier_escalator_unit #(
    parameter int HISTORY_DEPTH = crte_pkg::HISTORY_DEPTH_DEF,
    parameter int TIME_BITS     = crte_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [crte_pkg::NOW_W-1:0]        i_s_axis_tdata,  // now_time
    input  logic [crte_pkg::FUNC_W-1:0]       i_s_axis_tuser,  // func
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // current_tier, recommended_tier, recent_count, zero fill
    output logic [crte_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [crte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [crte_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import crte_pkg::*;

    t_cmd    cmd;
    t_status status;

    crte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_func     (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    crte_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TIME_BITS     (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (i_s_axis_tuser),
        .i_now_time  (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// File: rtl/crte_ram.sv
module crte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/crte_ctrl.sv
module crte_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [crte_pkg::FUNC_W-1:0]   i_func,
    output logic                          o_in_ready,
    output crte_pkg::t_cmd                o_cmd,
    input  crte_pkg::t_status             i_status
);
    import crte_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_func == FUNC_CLEAR) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/crte_dp.sv
module crte_dp #(
    parameter int HISTORY_DEPTH = crte_pkg::HISTORY_DEPTH_DEF,
    parameter int TIME_BITS     = crte_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [crte_pkg::FUNC_W-1:0]       i_func,
    input  logic [crte_pkg::NOW_W-1:0]        i_now_time,
    input  crte_pkg::t_cmd                    i_cmd,
    output crte_pkg::t_status                 o_status,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [crte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [crte_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [crte_pkg::OUT_DATA_W-1:0]   o_out_data
);
    import crte_pkg::*;

    localparam int IW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int SW   = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int CMPW = (CW > THR_W + 1) ? CW : THR_W + 1;

    logic [THR_W-1:0]         r_threshold;
    logic [WIN_W-1:0]         r_window;
    logic [TIER_W-1:0]        r_start_tier;
    logic [HISTORY_DEPTH-1:0] r_valid;
    logic [TIER_W-1:0]        r_sticky;
    logic                     r_ev;
    logic                     r_out_valid;

    logic [FUNC_W-1:0]        r_func;
    logic [TIME_BITS-1:0]     r_now;
    logic [IW-1:0]            r_idx;
    logic [IW-1:0]            r_ev_idx;
    logic [CW-1:0]            r_cnt;
    logic                     r_free_found;
    logic [IW-1:0]            r_free_slot;
    logic [TIME_BITS-1:0]     r_oldest;
    logic [IW-1:0]            r_old_slot;
    logic [OUT_DATA_W-1:0]    r_out_data;

    logic [TIME_BITS-1:0]     ram_q;
    logic                     ram_we;
    logic [TIME_BITS-1:0]     age;
    logic                     in_win;
    logic                     ent_valid;
    logic                     is_rec;
    logic                     prune;
    logic                     kept;
    logic                     take_free;
    logic                     take_old;
    logic [IW-1:0]            slot;
    logic [CW-1:0]            fin_cnt;
    logic [TIER_W-1:0]        rec_tier;
    logic [TIER_W-1:0]        n_sticky;
    logic [TIER_W-1:0]        floor_tier;
    logic [TIER_W-1:0]        cur_tier;
    logic [SW-1:0]            cnt_wide;
    logic [COUNT_W-1:0]       cnt_sat;
    logic [CMPW-1:0]          cnt_cmp;

    assign o_cfg_ready        = 1'b1;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.last_issue = (r_idx == IW'(HISTORY_DEPTH - 1));

    // entry evaluation, one stored time per cycle
    always_comb begin
        age       = r_now - ram_q;
        in_win    = (age <= TIME_BITS'(r_window));
        ent_valid = r_valid[r_ev_idx];
        is_rec    = (r_func == FUNC_RECORD);
        prune     = r_ev && is_rec && ent_valid && !in_win;
        kept      = r_ev && ent_valid && in_win;
        take_free = r_ev && !r_free_found && (!ent_valid || prune);
        take_old  = r_ev && ((r_ev_idx == '0) || (age > r_oldest));
    end

    // result of the item
    always_comb begin
        slot    = r_free_found ? r_free_slot : r_old_slot;
        fin_cnt = r_cnt;
        unique case (r_func)
            FUNC_RECORD: fin_cnt = r_cnt + CW'(r_free_found);
            FUNC_CLEAR:  fin_cnt = '0;
            default:     fin_cnt = r_cnt;
        endcase
        cnt_cmp  = CMPW'(fin_cnt);
        rec_tier = TIER_NORMAL;
        if (is_rec) begin
            if (cnt_cmp >= CMPW'({r_threshold, 1'b0})) begin
                rec_tier = TIER_FULL;
            end else if (cnt_cmp >= CMPW'(r_threshold)) begin
                rec_tier = TIER_NO_EXT;
            end
        end
        n_sticky   = (rec_tier > r_sticky) ? rec_tier : r_sticky;
        floor_tier = (r_start_tier > TIER_FULL) ? TIER_FULL : r_start_tier;
        cur_tier   = (n_sticky > floor_tier) ? n_sticky : floor_tier;
        cnt_wide   = SW'(fin_cnt);
        cnt_sat    = (cnt_wide > SW'(31)) ? 5'd31 : cnt_wide[COUNT_W-1:0];
    end

    assign ram_we = i_cmd.commit && is_rec;

    crte_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (HISTORY_DEPTH)
    ) u_times (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata (r_now),
        .i_re    (i_cmd.issue),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_window     <= WINDOW_RST;
            r_start_tier <= START_TIER_RST;
            r_valid      <= '0;
            r_sticky     <= TIER_NORMAL;
            r_ev         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_THRESHOLD:  r_threshold  <= i_cfg_data[THR_W-1:0];
                    REG_WINDOW:     r_window     <= i_cfg_data[WIN_W-1:0];
                    REG_START_TIER: r_start_tier <= i_cfg_data[TIER_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_ev <= i_cmd.issue;
            if (prune) begin
                r_valid[r_ev_idx] <= 1'b0;
            end
            if (i_cmd.commit) begin
                if (is_rec) begin
                    r_valid[slot] <= 1'b1;
                end else if (r_func == FUNC_CLEAR) begin
                    r_valid <= '0;
                end
                r_sticky    <= n_sticky;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func       <= i_func;
            r_now        <= TIME_BITS'(i_now_time);
            r_idx        <= '0;
            r_cnt        <= '0;
            r_free_found <= 1'b0;
            r_free_slot  <= '0;
            r_oldest     <= '0;
            r_old_slot   <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (kept) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (take_free) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_ev_idx;
            end
            if (take_old) begin
                r_oldest   <= age;
                r_old_slot <= r_ev_idx;
            end
        end
        if (i_cmd.issue) begin
            r_ev_idx <= r_idx;
        end
        if (i_cmd.commit) begin
            r_out_data <= {{(OUT_DATA_W - COUNT_W - 2 * TIER_W){1'b0}},
                           cnt_sat, rec_tier, cur_tier};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_no_stale_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_ev)
        else $error("entry evaluation still pending when a new word is loaded");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (SW'(r_out_data[2*TIER_W +: COUNT_W]) <= SW'(HISTORY_DEPTH)))
        else $error("reported count exceeds history depth");

    a_tier_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && $past(i_cmd.commit))
            |-> (r_out_data[TIER_W-1:0] >= r_out_data[TIER_W +: TIER_W]))
        else $error("current tier below recommended tier");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_func == FUNC_CLEAR) |=> (r_valid == '0))
        else $error("history not empty after clear");

endmodule
